>>> rtl/core/isotf_pkg.sv
// Shared types and constants of the ISO 8601 timestamp formatter.
package isotf_pkg;

  typedef struct packed {
    logic [3:0] y3;
    logic [3:0] y2;
    logic [3:0] y1;
    logic [3:0] y0;
    logic [3:0] mo1;
    logic [3:0] mo0;
    logic [3:0] d1;
    logic [3:0] d0;
    logic [3:0] h1;
    logic [3:0] h0;
    logic [3:0] m1;
    logic [3:0] m0;
    logic [3:0] s1;
    logic [3:0] s0;
    logic [3:0] f2;
    logic [3:0] f1;
    logic [3:0] f0;
  } digits_t;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZ     = 8'h5A;

  localparam logic [4:0] PosSecLo = 5'd18;
  localparam logic [4:0] PosZulu  = 5'd23;

  localparam logic [47:0] MaxEpochMs = 48'd253402300799999;

endpackage

>>> rtl/core/iso8601_timestamp_formatter.sv
// Top level of the ISO 8601 timestamp formatter: date pipeline and character serialiser.
//
// Each request carries a millisecond count since 1970-01-01T00:00:00Z and produces the
// text YYYY-MM-DDTHH:MM:SSZ (20 characters) or YYYY-MM-DDTHH:MM:SS.sssZ (24 characters,
// when with_millis is set), one character per output cycle while out_stall_i is low,
// with last_char on the Z. Counts beyond 9999-12-31T23:59:59.999Z saturate to that
// instant. Each count passes an input register, four stages that divide by the day
// length with a reciprocal multiplication and two correction steps, and then 14
// stages of calendar and digit arithmetic. A new request is taken while earlier ones
// are still in the pipeline or being sent, unless the last stage holds one waiting
// for the serialiser.
module iso8601_timestamp_formatter
  import isotf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] epoch_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);

  localparam int NumStages = 19;
  localparam logic [37:0] DayDiv = 38'd84375;
  localparam logic [18:0] DayRem = 19'd84375;
  localparam int SDay = 38;
  localparam logic [63:0] MDay = (64'd1 << 48) / 64'd84375;

  localparam int S1000 = 27 + $clog2(1000);
  localparam logic [63:0] M1000 = ((64'd1 << S1000) + 64'd999) / 64'd1000;
  localparam int SEra = 22 + $clog2(146097);
  localparam logic [63:0] MEra = ((64'd1 << SEra) + 64'd146096) / 64'd146097;
  localparam int S3600 = 17 + $clog2(3600);
  localparam logic [63:0] M3600 = ((64'd1 << S3600) + 64'd3599) / 64'd3600;
  localparam int S100 = 14 + $clog2(100);
  localparam logic [63:0] M100 = ((64'd1 << S100) + 64'd99) / 64'd100;
  localparam int S1460 = 18 + $clog2(1460);
  localparam logic [63:0] M1460 = ((64'd1 << S1460) + 64'd1459) / 64'd1460;
  localparam int S36524 = 18 + $clog2(36524);
  localparam logic [63:0] M36524 = ((64'd1 << S36524) + 64'd36523) / 64'd36524;
  localparam int S146096 = 18 + $clog2(146096);
  localparam logic [63:0] M146096 = ((64'd1 << S146096) + 64'd146095) / 64'd146096;
  localparam int S60 = 12 + $clog2(60);
  localparam logic [63:0] M60 = ((64'd1 << S60) + 64'd59) / 64'd60;
  localparam int S10 = 7 + $clog2(10);
  localparam logic [63:0] M10 = ((64'd1 << S10) + 64'd9) / 64'd10;
  localparam int S365 = 18 + $clog2(365);
  localparam logic [63:0] M365 = ((64'd1 << S365) + 64'd364) / 64'd365;
  localparam int S153 = 11 + $clog2(153);
  localparam logic [63:0] M153 = ((64'd1 << S153) + 64'd152) / 64'd153;
  localparam int S5 = 11 + $clog2(5);
  localparam logic [63:0] M5 = ((64'd1 << S5) + 64'd4) / 64'd5;

  function automatic logic [63:0] mdiv(input logic [63:0] n, input logic [63:0] m,
                                       input int s);
    mdiv = (n * m) >> s;
  endfunction

  function automatic logic [7:0] asc(input logic [3:0] d);
    asc = 8'(ChZero + {4'd0, d});
  endfunction

  logic [NumStages-1:0] v_q;
  logic adv, load, out_fire, with_millis_q;
  logic ser_v_q;
  logic [4:0] ser_idx_q, ser_idx_d;
  digits_t ser_dg_q;
  logic [7:0] line [24];
  logic [47:0] ms_sat;

  assign cfg_ready_o = 1'b1;
  assign out_fire = out_valid_o && !out_stall_i;
  assign load = !ser_v_q || (out_fire && last_char_o);
  assign adv = !v_q[NumStages-1] || load;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      with_millis_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      with_millis_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // The day count is estimated by a reciprocal of the day length and then corrected twice.
  logic [47:0] p_ms_q, q_ms_q;
  logic [21:0] q_quo_q, r_quo_q, s_quo_q, t_quo_q;
  logic [18:0] r_rem_q, s_rem_q, t_rem_q;
  logic [9:0]  r_lo_q, s_lo_q, t_lo_q;
  logic        r_ge, s_ge;

  assign ms_sat = (epoch_ms_i > MaxEpochMs) ? MaxEpochMs : epoch_ms_i;
  assign r_ge = r_rem_q >= DayRem;
  assign s_ge = s_rem_q >= DayRem;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_ms_q  <= ms_sat;
      q_ms_q  <= p_ms_q;
      q_quo_q <= 22'(mdiv(64'(p_ms_q[47:20]), MDay, SDay));
      r_rem_q <= 19'(q_ms_q[47:10] - 38'(q_quo_q) * DayDiv);
      r_quo_q <= q_quo_q;
      r_lo_q  <= q_ms_q[9:0];
      s_rem_q <= r_ge ? 19'(r_rem_q - DayRem) : r_rem_q;
      s_quo_q <= 22'(r_quo_q + 22'(r_ge));
      s_lo_q  <= r_lo_q;
      t_rem_q <= s_ge ? 19'(s_rem_q - DayRem) : s_rem_q;
      t_quo_q <= 22'(s_quo_q + 22'(s_ge));
      t_lo_q  <= s_lo_q;
    end
  end

  logic [26:0] tod;
  assign tod = {t_rem_q[16:0], t_lo_q};

  logic [21:0] a_z_q, b_z_q;
  logic [26:0] a_tod_q;
  logic [16:0] a_sec_q, b_sec_q;
  logic [4:0]  b_era_q, c_era_q, d_era_q, e_era_q, f_era_q;
  logic [9:0]  b_sub_q, c_sub_q;
  logic [4:0]  b_hh_q, c_hh_q, d_hh_q, e_hh_q;
  logic [17:0] c_doe_q, d_doe_q, e_doe_q, f_doe_q, g_doe_q;
  logic [11:0] c_rest_q, d_rest_q;
  logic [6:0]  d_q1_q;
  logic [2:0]  d_q2_q;
  logic        d_q3_q;
  logic [5:0]  d_mi_q, e_mi_q, e_ss_q, f_ss_q;
  logic [6:0]  d_fr_q, e_fr_q;
  logic [17:0] e_t_q;
  logic [8:0]  f_yoe_q, g_yoe_q;
  logic [1:0]  g_y100_q;
  logic [17:0] g_y365_q;
  logic [13:0] g_era400_q;
  logic [8:0]  h_doy_q, i_doy_q, j_doy_q;
  logic [13:0] h_year0_q, i_year0_q, j_year_q, k_year_q;
  logic [3:0]  i_mp_q, j_month_q, k_month_q, j_mon_d;
  logic [10:0] j_x_q;
  logic [4:0]  k_day_q, l_day_q;
  logic [6:0]  k_yh_q, l_yh_q, l_yl_q, m_yl_q;
  digits_t c_dg_q, d_dg_q, e_dg_q, f_dg_q, g_dg_q, h_dg_q, i_dg_q;
  digits_t j_dg_q, k_dg_q, l_dg_q, m_dg_q, n_dg_q;
  digits_t c_dg_d, e_dg_d, f_dg_d, g_dg_d, k_dg_d, l_dg_d, m_dg_d, n_dg_d;

  always_comb begin
    c_dg_d = '0;
    c_dg_d.f2 = 4'(mdiv(64'(b_sub_q), M100, S100));
    e_dg_d = d_dg_q;
    e_dg_d.h1 = 4'(mdiv(64'(d_hh_q), M10, S10));
    e_dg_d.m1 = 4'(mdiv(64'(d_mi_q), M10, S10));
    e_dg_d.f1 = 4'(mdiv(64'(d_fr_q), M10, S10));
    f_dg_d = e_dg_q;
    f_dg_d.h0 = 4'(7'(e_hh_q) - 7'(e_dg_q.h1) * 7'd10);
    f_dg_d.m0 = 4'(7'(e_mi_q) - 7'(e_dg_q.m1) * 7'd10);
    f_dg_d.s1 = 4'(mdiv(64'(e_ss_q), M10, S10));
    f_dg_d.f0 = 4'(7'(e_fr_q) - 7'(e_dg_q.f1) * 7'd10);
    g_dg_d = f_dg_q;
    g_dg_d.s0 = 4'(7'(f_ss_q) - 7'(f_dg_q.s1) * 7'd10);
    k_dg_d = j_dg_q;
    k_dg_d.mo1 = 4'(mdiv(64'(j_month_q), M10, S10));
    l_dg_d = k_dg_q;
    l_dg_d.d1  = 4'(mdiv(64'(k_day_q), M10, S10));
    l_dg_d.mo0 = 4'(7'(k_month_q) - 7'(k_dg_q.mo1) * 7'd10);
    l_dg_d.y3  = 4'(mdiv(64'(k_yh_q), M10, S10));
    m_dg_d = l_dg_q;
    m_dg_d.d0 = 4'(7'(l_day_q) - 7'(l_dg_q.d1) * 7'd10);
    m_dg_d.y1 = 4'(mdiv(64'(l_yl_q), M10, S10));
    m_dg_d.y2 = 4'(l_yh_q - 7'(l_dg_q.y3) * 7'd10);
    n_dg_d = m_dg_q;
    n_dg_d.y0 = 4'(m_yl_q - 7'(m_dg_q.y1) * 7'd10);
    j_mon_d = (i_mp_q < 4'd10) ? 4'(i_mp_q + 4'd3) : 4'(i_mp_q - 4'd9);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_z_q   <= 22'(t_quo_q + 22'd719468);
      a_tod_q <= tod;
      a_sec_q <= 17'(mdiv(64'(tod), M1000, S1000));

      b_z_q   <= a_z_q;
      b_era_q <= 5'(mdiv(64'(a_z_q), MEra, SEra));
      b_sub_q <= 10'(a_tod_q - 27'(a_sec_q) * 27'd1000);
      b_sec_q <= a_sec_q;
      b_hh_q  <= 5'(mdiv(64'(a_sec_q), M3600, S3600));

      c_doe_q  <= 18'(b_z_q - 22'(b_era_q) * 22'd146097);
      c_era_q  <= b_era_q;
      c_rest_q <= 12'(b_sec_q - 17'(b_hh_q) * 17'd3600);
      c_hh_q   <= b_hh_q;
      c_sub_q  <= b_sub_q;
      c_dg_q   <= c_dg_d;

      d_q1_q   <= 7'(mdiv(64'(c_doe_q), M1460, S1460));
      d_q2_q   <= 3'(mdiv(64'(c_doe_q), M36524, S36524));
      d_q3_q   <= 1'(mdiv(64'(c_doe_q), M146096, S146096));
      d_doe_q  <= c_doe_q;
      d_era_q  <= c_era_q;
      d_rest_q <= c_rest_q;
      d_mi_q   <= 6'(mdiv(64'(c_rest_q), M60, S60));
      d_hh_q   <= c_hh_q;
      d_fr_q   <= 7'(c_sub_q - 10'(c_dg_q.f2) * 10'd100);
      d_dg_q   <= c_dg_q;

      e_t_q   <= 18'(d_doe_q - 18'(d_q1_q) + 18'(d_q2_q) - 18'(d_q3_q));
      e_doe_q <= d_doe_q;
      e_era_q <= d_era_q;
      e_ss_q  <= 6'(d_rest_q - 12'(d_mi_q) * 12'd60);
      e_hh_q  <= d_hh_q;
      e_mi_q  <= d_mi_q;
      e_fr_q  <= d_fr_q;
      e_dg_q  <= e_dg_d;

      f_yoe_q <= 9'(mdiv(64'(e_t_q), M365, S365));
      f_doe_q <= e_doe_q;
      f_era_q <= e_era_q;
      f_ss_q  <= e_ss_q;
      f_dg_q  <= f_dg_d;

      g_y100_q   <= 2'(mdiv(64'(f_yoe_q), M100, S100));
      g_y365_q   <= 18'(18'(f_yoe_q) * 18'd365);
      g_era400_q <= 14'(14'(f_era_q) * 14'd400);
      g_yoe_q    <= f_yoe_q;
      g_doe_q    <= f_doe_q;
      g_dg_q     <= g_dg_d;

      h_doy_q   <= 9'(g_doe_q - (g_y365_q + 18'(g_yoe_q >> 2) - 18'(g_y100_q)));
      h_year0_q <= 14'(14'(g_yoe_q) + g_era400_q);
      h_dg_q    <= g_dg_q;

      i_mp_q    <= 4'(mdiv(64'(11'(h_doy_q) * 11'd5 + 11'd2), M153, S153));
      i_doy_q   <= h_doy_q;
      i_year0_q <= h_year0_q;
      i_dg_q    <= h_dg_q;

      j_month_q <= j_mon_d;
      j_x_q     <= 11'(11'(i_mp_q) * 11'd153 + 11'd2);
      j_year_q  <= 14'(i_year0_q + 14'(j_mon_d <= 4'd2));
      j_doy_q   <= i_doy_q;
      j_dg_q    <= i_dg_q;

      k_day_q   <= 5'(j_doy_q - 9'(mdiv(64'(j_x_q), M5, S5)) + 9'd1);
      k_yh_q    <= 7'(mdiv(64'(j_year_q), M100, S100));
      k_month_q <= j_month_q;
      k_year_q  <= j_year_q;
      k_dg_q    <= k_dg_d;

      l_day_q <= k_day_q;
      l_yh_q  <= k_yh_q;
      l_yl_q  <= 7'(k_year_q - 14'(k_yh_q) * 14'd100);
      l_dg_q  <= l_dg_d;

      m_yl_q  <= l_yl_q;
      m_dg_q  <= m_dg_d;

      n_dg_q <= n_dg_d;
    end
  end

  always_comb begin
    line[0]  = asc(ser_dg_q.y3);
    line[1]  = asc(ser_dg_q.y2);
    line[2]  = asc(ser_dg_q.y1);
    line[3]  = asc(ser_dg_q.y0);
    line[4]  = ChDash;
    line[5]  = asc(ser_dg_q.mo1);
    line[6]  = asc(ser_dg_q.mo0);
    line[7]  = ChDash;
    line[8]  = asc(ser_dg_q.d1);
    line[9]  = asc(ser_dg_q.d0);
    line[10] = ChT;
    line[11] = asc(ser_dg_q.h1);
    line[12] = asc(ser_dg_q.h0);
    line[13] = ChColon;
    line[14] = asc(ser_dg_q.m1);
    line[15] = asc(ser_dg_q.m0);
    line[16] = ChColon;
    line[17] = asc(ser_dg_q.s1);
    line[18] = asc(ser_dg_q.s0);
    line[19] = ChDot;
    line[20] = asc(ser_dg_q.f2);
    line[21] = asc(ser_dg_q.f1);
    line[22] = asc(ser_dg_q.f0);
    line[23] = ChZ;
    ser_idx_d = (ser_idx_q == PosSecLo && !with_millis_q) ? PosZulu : 5'(ser_idx_q + 5'd1);
  end

  assign out_valid_o = ser_v_q;
  assign char_code_o = line[ser_idx_q];
  assign last_char_o = ser_idx_q == PosZulu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_idx_q <= '0;
    end else if (load) begin
      ser_v_q   <= v_q[NumStages-1];
      ser_idx_q <= '0;
    end else if (out_fire) begin
      ser_idx_q <= ser_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_dg_q <= n_dg_q;
    end
  end

  a_last_is_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> char_code_o == ChZ)
    else $error("last character is not Z");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_v_q |-> ser_idx_q <= PosZulu)
    else $error("character index out of range");

  a_no_millis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_v_q && !with_millis_q |-> (ser_idx_q <= PosSecLo || ser_idx_q == PosZulu))
    else $error("millisecond characters sent while disabled");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_q[NumStages-1] && ser_v_q)
    else $error("input stalled with room in the pipeline");

endmodule
